/* design/csem_pkg.sv */
// ----------------------------------------------------------------------------
// csem_pkg
// Shared constants and types of the counting semaphore with a waiter queue.
// ----------------------------------------------------------------------------
package csem_pkg;

  localparam int MaxWaiters = 8;
  localparam int CountWidth = 16;

  localparam int PtrWidth = (MaxWaiters > 1) ? $clog2(MaxWaiters) : 1;
  localparam int LenWidth = $clog2(MaxWaiters + 1);

  localparam longint CountMaxL = (64'sd1 <<< (CountWidth - 1)) - 64'sd1;
  localparam longint CountMinL = -(64'sd1 <<< (CountWidth - 1));

  typedef enum logic [1:0] {
    ACT_WAIT    = 2'd0,
    ACT_SIGNAL  = 2'd1,
    ACT_TRYWAIT = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_GRANTED     = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_FULL        = 3'd2,
    ST_WOULD_BLOCK = 3'd3,
    ST_SIGNALED    = 3'd4,
    ST_SATURATED   = 3'd5
  } status_e;

  typedef enum logic {
    S_EMPTY = 1'b0,
    S_HOLD  = 1'b1
  } state_e;

  typedef struct packed {
    logic exec;
    logic reload;
  } csem_cmd_t;

endpackage

/* design/csem_ctrl.sv */
// ----------------------------------------------------------------------------
// csem_ctrl
// Handshake controller: tracks whether a result word is held at the output.
// ----------------------------------------------------------------------------
module csem_ctrl import csem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  logic      cfg_we_i,
  output csem_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o.exec   = 1'b0;
    cmd_o.reload = cfg_we_i;
    unique case (state_q)
      S_EMPTY: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_HOLD;
        end
      end
      S_HOLD: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            cmd_o.exec = 1'b1;
          end else begin
            state_d = S_EMPTY;
          end
        end
      end
      default: state_d = S_EMPTY;
    endcase
  end

endmodule

/* design/csem_dp.sv */
// ----------------------------------------------------------------------------
// csem_dp
// Datapath: count register, waiter ring and the result word register.
// ----------------------------------------------------------------------------
module csem_dp import csem_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  csem_cmd_t       cmd_i,
  input  logic [15:0]     cfg_wdata_i,
  input  logic [1:0]      action_i,
  input  logic [15:0]     requester_task_i,
  input  logic [7:0]      requester_thread_i,
  output logic [2:0]      status_o,
  output logic            woke_valid_o,
  output logic [15:0]     woke_task_o,
  output logic [7:0]      woke_thread_o,
  output logic signed [15:0] count_value_o,
  output logic [3:0]      waiters_now_o
);

  localparam logic signed [CountWidth-1:0] CountMax = CountWidth'(CountMaxL);
  localparam logic signed [CountWidth-1:0] CountMin = CountWidth'(CountMinL);
  localparam logic [PtrWidth:0] RingSize = (PtrWidth + 1)'(MaxWaiters);

  logic signed [CountWidth-1:0] count_q, count_d;
  logic [PtrWidth-1:0]          head_q, head_d;
  logic [LenWidth-1:0]          len_q, len_d;
  logic [15:0]                  task_q   [MaxWaiters];
  logic [7:0]                   thread_q [MaxWaiters];

  logic [2:0]  status_q, status_d;
  logic        woke_q, woke_d;
  logic [15:0] wtask_q, wtask_d;
  logic [7:0]  wthread_q, wthread_d;

  logic signed [15:0] cfg_val;
  logic [PtrWidth:0]  tail_sum, head_inc;
  logic [PtrWidth-1:0] tail_idx;
  logic               push;
  action_e            act;

  assign cfg_val = signed'(cfg_wdata_i);
  assign act     = action_e'(action_i);

  assign tail_sum = (PtrWidth + 1)'(head_q) + (PtrWidth + 1)'(len_q);
  assign tail_idx = (tail_sum >= RingSize) ? PtrWidth'(tail_sum - RingSize)
                                           : PtrWidth'(tail_sum);
  assign head_inc = (PtrWidth + 1)'(head_q) + (PtrWidth + 1)'(1);

  always_comb begin
    count_d   = count_q;
    head_d    = head_q;
    len_d     = len_q;
    status_d  = status_q;
    woke_d    = woke_q;
    wtask_d   = wtask_q;
    wthread_d = wthread_q;
    push      = 1'b0;
    if (cmd_i.reload) begin
      if (longint'(cfg_val) > CountMaxL) begin
        count_d = CountMax;
      end else if (longint'(cfg_val) < CountMinL) begin
        count_d = CountMin;
      end else begin
        count_d = CountWidth'(cfg_val);
      end
      head_d = '0;
      len_d  = '0;
    end else if (cmd_i.exec) begin
      status_d  = ST_GRANTED;
      woke_d    = 1'b0;
      wtask_d   = '0;
      wthread_d = '0;
      unique case (act)
        ACT_WAIT: begin
          if (count_q > 0) begin
            count_d = count_q - CountWidth'(1);
          end else if (len_q < LenWidth'(MaxWaiters)) begin
            push     = 1'b1;
            len_d    = len_q + LenWidth'(1);
            status_d = ST_QUEUED;
          end else begin
            status_d = ST_FULL;
          end
        end
        ACT_SIGNAL: begin
          if (count_q == CountMax) begin
            status_d = ST_SATURATED;
          end else begin
            count_d  = count_q + CountWidth'(1);
            status_d = ST_SIGNALED;
          end
          if (len_q != '0) begin
            woke_d    = 1'b1;
            wtask_d   = task_q[head_q];
            wthread_d = thread_q[head_q];
            head_d    = (head_inc >= RingSize) ? '0 : PtrWidth'(head_inc);
            len_d     = len_q - LenWidth'(1);
          end
        end
        ACT_TRYWAIT: begin
          if (count_q > 0) begin
            count_d = count_q - CountWidth'(1);
          end else begin
            status_d = ST_WOULD_BLOCK;
          end
        end
        ACT_READ: status_d = ST_GRANTED;
        default:  status_d = ST_GRANTED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      head_q   <= '0;
      len_q    <= '0;
    end else begin
      count_q  <= count_d;
      head_q   <= head_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    woke_q    <= woke_d;
    wtask_q   <= wtask_d;
    wthread_q <= wthread_d;
    if (push) begin
      task_q[tail_idx]   <= requester_task_i;
      thread_q[tail_idx] <= requester_thread_i;
    end
  end

  assign status_o      = status_q;
  assign woke_valid_o  = woke_q;
  assign woke_task_o   = wtask_q;
  assign woke_thread_o = wthread_q;
  assign count_value_o = 16'(longint'(count_q));
  assign waiters_now_o = 4'(len_q);

endmodule

/* design/counting_semaphore_fifo_waiters_core.sv */
// Result: a result word is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register is reloaded in the
// same cycle the held word is taken, so only a stalled consumer slows it.
// Reset: count, ring head and waiter count clear to zero; queue entries are
// not cleared and are only read after being written.
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_core
// Counting semaphore with a FIFO of waiting requesters.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_core import csem_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [15:0]        requester_task_i,
  input  logic [7:0]         requester_thread_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic               woke_valid_o,
  output logic [15:0]        woke_task_o,
  output logic [7:0]         woke_thread_o,
  output logic signed [15:0] count_value_o,
  output logic [3:0]         waiters_now_o
);

  csem_cmd_t cmd;

  csem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cmd_o       (cmd)
  );

  csem_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_wdata_i        (cfg_wdata_i),
    .action_i           (action_i),
    .requester_task_i   (requester_task_i),
    .requester_thread_i (requester_thread_i),
    .status_o           (status_o),
    .woke_valid_o       (woke_valid_o),
    .woke_task_o        (woke_task_o),
    .woke_thread_o      (woke_thread_o),
    .count_value_o      (count_value_o),
    .waiters_now_o      (waiters_now_o)
  );

endmodule
